[rtl/alaf_pkg.sv]
// ----------------------------------------------------------------------------
// alaf_pkg
// Types and codes shared by the attenuator level feedback logic.
// ----------------------------------------------------------------------------
package alaf_pkg;

  // attenuation setting in dB
  typedef logic [5:0] att_t;

  // verdict gathered over one pass of bunches
  typedef enum logic [2:0] {
    V_NONE  = 3'd0,
    V_UP    = 3'd1,
    V_SAT   = 3'd2,
    V_SLOW  = 3'd3,
    V_NOISE = 3'd4,
    V_BAND  = 3'd5
  } verdict_t;

  // decision code reported with each result
  typedef enum logic [2:0] {
    DEC_KEEP  = 3'd0,
    DEC_UP    = 3'd1,
    DEC_SAT   = 3'd2,
    DEC_SLOW  = 3'd3,
    DEC_NOISE = 3'd4
  } decision_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FEEDBACK_ENABLE   = 3'd0,
    REG_UPPER_PERCENT     = 3'd1,
    REG_LOWER_PERCENT     = 3'd2,
    REG_LOW_RUN_NEEDED    = 3'd3,
    REG_STEP_UP_DB        = 3'd4,
    REG_NOISE_RULE_ENABLE = 3'd5
  } reg_index_t;

  localparam logic [6:0]  PCT_MAX       = 7'd100;
  localparam att_t        ATT_MAX       = 6'd63;
  localparam att_t        SAT_STEP_DB   = 6'd6;
  localparam logic [15:0] NOISE_FLOOR   = 16'd200;
  localparam att_t        NOISE_ATT_MIN = 6'd20;
  localparam logic [8:0]  RUN_MAX       = 9'd511;

endpackage

[rtl/adc_level_attenuator_feedback_unit.sv]
// ----------------------------------------------------------------------------
// adc_level_attenuator_feedback_unit
// Per-bunch amplitude classification and end-of-pass attenuator stepping.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// in_      in_valid/in_ready     amplitude, attenuation_now, last_bunch
// out_     out_valid/out_ready   attenuation_new, write_attenuator, decision
// cfg_     cfg_valid/cfg_ready   index (3b), data (8b); ready always high
//
// One bunch per cycle while the result is not stalled; the result of an enabled
// pass goes from its final bunch in the input register to the result reg.
// The limit codes are registered from the configuration registers.
// Reset (rst_n low, synchronous) restores register defaults and clears the
// pass state and run counter. A stalled result holds the input stage; the
// input register then holds and in_ready drops.
// ----------------------------------------------------------------------------
module adc_level_attenuator_feedback_unit #(
  parameter int unsigned      AMP_BITS          = 16,
  parameter longint unsigned  FULL_SCALE_CODE   = 65535,
  parameter longint unsigned  SATURATION_CODE   = 65000,
  parameter int unsigned      LIMIT_GAP_PERCENT = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  // bunch input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_amplitude,
  input  alaf_pkg::att_t     in_attenuation_now,
  input  logic               in_last_bunch,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output alaf_pkg::att_t     out_attenuation_new,
  output logic               out_write_attenuator,
  output logic [2:0]         out_decision,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import alaf_pkg::*;

  localparam logic [15:0] AMP_MASK = (AMP_BITS >= 16) ? 16'hFFFF
                                   : 16'((32'd1 << AMP_BITS) - 32'd1);
  localparam logic [7:0]  GAP      = 8'(LIMIT_GAP_PERCENT);
  localparam logic [31:0] SAT_CODE = 32'(SATURATION_CODE);

  // configuration registers
  logic       fb_en_r;
  logic [6:0] upper_r;
  logic [6:0] lower_r;
  logic [7:0] run_needed_r;
  att_t       step_up_r;
  logic       noise_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_en_r      <= 1'b1;
      upper_r      <= 7'd70;
      lower_r      <= 7'd50;
      run_needed_r <= 8'd1;
      step_up_r    <= 6'd6;
      noise_en_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_FEEDBACK_ENABLE:   fb_en_r      <= cfg_data[0];
        REG_UPPER_PERCENT:     upper_r      <= cfg_data[6:0];
        REG_LOWER_PERCENT:     lower_r      <= cfg_data[6:0];
        REG_LOW_RUN_NEEDED:    run_needed_r <= cfg_data;
        REG_STEP_UP_DB:        step_up_r    <= cfg_data[5:0];
        REG_NOISE_RULE_ENABLE: noise_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // percent to code table, percent * full scale / 100
  logic [31:0] lim_tbl [0:100];
  for (genvar g = 0; g <= 100; g++) begin : g_lim
    assign lim_tbl[g] = 32'((64'(g) * 64'(FULL_SCALE_CODE)) / 64'd100);
  end

  // limit clamping
  logic [7:0] up_pct;
  logic [7:0] lo_pct;

  always_comb begin
    up_pct = (upper_r > PCT_MAX) ? {1'b0, PCT_MAX} : {1'b0, upper_r};
    if (up_pct < GAP) up_pct = GAP;
    lo_pct = {1'b0, lower_r};
    if (lo_pct + GAP > up_pct) lo_pct = (lo_pct > GAP) ? (up_pct - GAP) : 8'd0;
  end

  logic [31:0] up_code_r;
  logic [31:0] lo_code_r;

  always_ff @(posedge clk) begin
    up_code_r <= lim_tbl[up_pct[6:0]];
    lo_code_r <= lim_tbl[lo_pct[6:0]];
  end

  // input register
  logic        s1_valid_r;
  logic [15:0] s1_amp_r;
  att_t        s1_att_r;
  logic        s1_last_r;
  logic        s1_adv;
  logic        out_valid_r;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_amp_r  <= in_amplitude & AMP_MASK;
      s1_att_r  <= in_attenuation_now;
      s1_last_r <= in_last_bunch;
    end
  end

  // pass state
  verdict_t   verdict_r;
  logic       stopped_r;
  logic [8:0] run_cnt_r;

  // classification of the bunch in the input register
  verdict_t   cls_verdict;
  logic       cls_stop;
  logic [31:0] amp_w;

  assign amp_w = {16'd0, s1_amp_r};

  always_comb begin
    cls_verdict = verdict_r;
    cls_stop    = stopped_r;
    if (!stopped_r) begin
      priority if (amp_w >= SAT_CODE) begin
        cls_verdict = V_SAT;
        cls_stop    = 1'b1;
      end else if (amp_w > up_code_r) begin
        cls_verdict = V_UP;
        cls_stop    = 1'b1;
      end else if (amp_w > lo_code_r) begin
        cls_verdict = V_BAND;
      end else if (!noise_en_r || s1_amp_r > NOISE_FLOOR) begin
        if (verdict_r == V_NONE) cls_verdict = V_SLOW;
      end else if (s1_att_r > NOISE_ATT_MIN) begin
        if (verdict_r == V_NONE) cls_verdict = V_NOISE;
      end else begin
        // below the noise floor at low attenuation nothing is asked for
        cls_verdict = verdict_r;
      end
    end
  end

  // end-of-pass decision
  att_t       res_att;
  logic       res_wr;
  decision_t  res_dec;
  logic [8:0] res_cnt;
  att_t       inc;
  logic [6:0] sum;

  always_comb begin
    inc     = (step_up_r == '0) ? 6'd1 : step_up_r;
    sum     = '0;
    res_att = s1_att_r;
    res_wr  = 1'b0;
    res_dec = DEC_KEEP;
    res_cnt = run_cnt_r;
    unique case (cls_verdict)
      V_UP: begin
        sum     = {1'b0, s1_att_r} + {1'b0, inc};
        res_att = (sum > {1'b0, ATT_MAX}) ? ATT_MAX : sum[5:0];
        res_wr  = 1'b1;
        res_dec = DEC_UP;
        res_cnt = '0;
      end
      V_SAT: begin
        sum     = {1'b0, s1_att_r} + {1'b0, SAT_STEP_DB};
        res_att = (sum > {1'b0, ATT_MAX}) ? ATT_MAX : sum[5:0];
        res_wr  = 1'b1;
        res_dec = DEC_SAT;
        res_cnt = '0;
      end
      V_SLOW: begin
        if (s1_att_r != '0) begin
          if (run_cnt_r > {1'b0, run_needed_r}) begin
            res_att = s1_att_r - 6'd1;
            res_cnt = '0;
          end else if (run_cnt_r < RUN_MAX) begin
            res_cnt = run_cnt_r + 9'd1;
          end
        end
        res_wr  = 1'b1;
        res_dec = DEC_SLOW;
      end
      V_NOISE: begin
        if (s1_att_r != '0) begin
          res_att = s1_att_r - 6'd1;
          res_cnt = '0;
        end
        res_wr  = 1'b1;
        res_dec = DEC_NOISE;
      end
      default: begin
        res_cnt = '0;
      end
    endcase
  end

  logic s1_fire;
  logic s1_result;

  assign s1_fire   = s1_valid_r && s1_adv;
  assign s1_result = s1_last_r && fb_en_r;

  // pass state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verdict_r <= V_NONE;
      stopped_r <= 1'b0;
      run_cnt_r <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        verdict_r <= V_NONE;
        stopped_r <= 1'b0;
        if (fb_en_r) run_cnt_r <= res_cnt;
      end else begin
        verdict_r <= cls_verdict;
        stopped_r <= cls_stop;
      end
    end
  end

  // result register
  att_t      out_att_r;
  logic      out_wr_r;
  decision_t out_dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r && s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      out_att_r <= res_att;
      out_wr_r  <= res_wr;
      out_dec_r <= res_dec;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_attenuation_new  = out_att_r;
  assign out_write_attenuator = out_wr_r;
  assign out_decision         = out_dec_r;

  // checks
  a_wr_matches_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_wr_r == (out_dec_r != DEC_KEEP)))
    else $error("write flag disagrees with decision");

  a_stop_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (verdict_r == V_UP || verdict_r == V_SAT))
    else $error("scan stopped without an over-limit verdict");

  a_pass_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (verdict_r == V_NONE && !stopped_r))
    else $error("pass state not cleared at pass end");

  a_up_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_result && (res_dec == DEC_UP || res_dec == DEC_SAT))
      |=> (run_cnt_r == '0))
    else $error("run counter not cleared on step up");

endmodule
